@@ rtl/core/scc_pkg.sv @@
// Shared types and constants for the strongly connected components block.
`timescale 1ns / 1ps

package scc_pkg;

    localparam int LETTER_W     = 21;
    localparam int OP_W         = 2;
    localparam int COMP_NUM_W   = 5;
    localparam int SIZE_W       = 6;
    localparam int COUNT_W      = 6;
    localparam int RESULT_LIMIT = 32;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 40;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
    localparam logic [OP_W-1:0] OP_ANALYSE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;
        logic latch;
        logic find_b;
        logic find_step;
        logic find_hit;
        logic find_miss;
        logic edge_set;
        logic out_empty;
        logic ana_start;
        logic rk_load;
        logic rk_scan;
        logic rk_store;
        logic i_clear;
        logic rm_load;
        logic rm_scan;
        logic rm_store;
        logic t_init;
        logic root_skip;
        logic root_pick;
        logic visit;
        logic step_adv;
        logic step_done;
        logic pop;
        logic ret_upd;
        logic sel_start;
        logic sel_scan;
        logic emit_start;
        logic emit_skip;
        logic emit_out;
        logic emit_next;
    } scc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic n_zero;
        logic j_end;
        logic i_end;
        logic find_hit;
        logic root_seen;
        logic rest_any;
        logic w_new;
        logic is_root;
        logic pop_last;
        logic depth_zero;
        logic sel_end;
        logic best_none;
        logic r_match;
        logic out_free;
        logic run_last;
    } scc_stat_t;

endpackage

@@ rtl/core/scc_ctrl.sv @@
// Controller state machine: load, rank, remap, depth-first search, ordering and emission.
`timescale 1ns / 1ps

module scc_ctrl import scc_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [OP_W-1:0] s_op,
    output logic            s_ready,
    input  scc_stat_t       stat,
    output scc_cmd_t        cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_FIND_A  = 4'd1;
    localparam logic [3:0] ST_FIND_B  = 4'd2;
    localparam logic [3:0] ST_EDGE    = 4'd3;
    localparam logic [3:0] ST_EMPTY   = 4'd4;
    localparam logic [3:0] ST_RK_LOAD = 4'd5;
    localparam logic [3:0] ST_RK_SCAN = 4'd6;
    localparam logic [3:0] ST_RM_LOAD = 4'd7;
    localparam logic [3:0] ST_RM_SCAN = 4'd8;
    localparam logic [3:0] ST_T_ROOT  = 4'd9;
    localparam logic [3:0] ST_T_VISIT = 4'd10;
    localparam logic [3:0] ST_T_STEP  = 4'd11;
    localparam logic [3:0] ST_T_POP   = 4'd12;
    localparam logic [3:0] ST_T_RET   = 4'd13;
    localparam logic [3:0] ST_SEL     = 4'd14;
    localparam logic [3:0] ST_EMIT    = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_op)
                        OP_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        OP_ADD: begin
                            cmd.latch  = 1'b1;
                            state_next = ST_FIND_A;
                        end
                        OP_ANALYSE: begin
                            if (stat.n_zero) begin
                                state_next = ST_EMPTY;
                            end else begin
                                cmd.ana_start = 1'b1;
                                state_next    = ST_RK_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIND_A, ST_FIND_B: begin
                cmd.find_b = (state_reg == ST_FIND_B);
                priority if (stat.j_end) begin
                    cmd.find_miss = 1'b1;
                    state_next    = (state_reg == ST_FIND_B) ? ST_EDGE : ST_FIND_B;
                end else if (stat.find_hit) begin
                    cmd.find_hit = 1'b1;
                    state_next   = (state_reg == ST_FIND_B) ? ST_EDGE : ST_FIND_B;
                end else begin
                    cmd.find_step = 1'b1;
                end
            end
            ST_EDGE: begin
                cmd.edge_set = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_EMPTY: begin
                if (stat.out_free) begin
                    cmd.out_empty = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RK_LOAD: begin
                if (stat.i_end) begin
                    cmd.i_clear = 1'b1;
                    state_next  = ST_RM_LOAD;
                end else begin
                    cmd.rk_load = 1'b1;
                    state_next  = ST_RK_SCAN;
                end
            end
            ST_RK_SCAN: begin
                if (stat.j_end) begin
                    cmd.rk_store = 1'b1;
                    state_next   = ST_RK_LOAD;
                end else begin
                    cmd.rk_scan = 1'b1;
                end
            end
            ST_RM_LOAD: begin
                if (stat.i_end) begin
                    cmd.t_init = 1'b1;
                    state_next = ST_T_ROOT;
                end else begin
                    cmd.rm_load = 1'b1;
                    state_next  = ST_RM_SCAN;
                end
            end
            ST_RM_SCAN: begin
                if (stat.j_end) begin
                    cmd.rm_store = 1'b1;
                    state_next   = ST_RM_LOAD;
                end else begin
                    cmd.rm_scan = 1'b1;
                end
            end
            ST_T_ROOT: begin
                priority if (stat.i_end) begin
                    cmd.sel_start = 1'b1;
                    state_next    = ST_SEL;
                end else if (stat.root_seen) begin
                    cmd.root_skip = 1'b1;
                end else begin
                    cmd.root_pick = 1'b1;
                    state_next    = ST_T_VISIT;
                end
            end
            ST_T_VISIT: begin
                cmd.visit  = 1'b1;
                state_next = ST_T_STEP;
            end
            ST_T_STEP: begin
                if (stat.rest_any) begin
                    cmd.step_adv = 1'b1;
                    if (stat.w_new) begin
                        state_next = ST_T_VISIT;
                    end
                end else begin
                    cmd.step_done = 1'b1;
                    state_next    = stat.is_root ? ST_T_POP : ST_T_RET;
                end
            end
            ST_T_POP: begin
                cmd.pop = 1'b1;
                if (stat.pop_last) begin
                    state_next = ST_T_RET;
                end
            end
            ST_T_RET: begin
                if (stat.depth_zero) begin
                    state_next = ST_T_ROOT;
                end else begin
                    cmd.ret_upd = 1'b1;
                    state_next  = ST_T_STEP;
                end
            end
            ST_SEL: begin
                if (stat.sel_end) begin
                    if (stat.best_none) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT;
                    end
                end else begin
                    cmd.sel_scan = 1'b1;
                end
            end
            ST_EMIT: begin
                priority if (stat.j_end) begin
                    cmd.emit_next = 1'b1;
                    state_next    = ST_SEL;
                end else if (stat.r_match) begin
                    if (stat.out_free) begin
                        cmd.emit_out = 1'b1;
                        if (stat.run_last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    cmd.emit_skip = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/scc_dp.sv @@
// Datapath: letter table, adjacency, ranking, search stacks, ordering and output register.
`timescale 1ns / 1ps

module scc_dp import scc_pkg::*; #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  scc_cmd_t              cmd,
    output scc_stat_t             stat,
    input  logic [LETTER_W-1:0]   in_first,
    input  logic [LETTER_W-1:0]   in_second,
    input  logic                  in_edge,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [COMP_NUM_W-1:0] out_comp,
    output logic [LETTER_W-1:0]   out_letter,
    output logic [SIZE_W-1:0]     out_size,
    output logic                  out_last_comp,
    output logic                  out_last_run,
    output logic                  out_empty,
    output logic                  out_ovf
);

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // graph store
    logic [LETTER_W-1:0]     letter_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj_reg    [MAX_VERTICES];
    logic [CW-1:0]           vcount_reg;
    logic                    ovf_reg;

    // bigram request
    logic [LETTER_W-1:0] first_reg, second_reg;
    logic                edge_reg;
    logic [IW-1:0]       a_idx_reg, b_idx_reg;
    logic                a_ok_reg, b_ok_reg;

    // scan counters
    logic [CW-1:0] i_reg, j_reg;
    logic [IW-1:0] i_idx, j_idx;

    // ranking and remap
    logic [LETTER_W-1:0]     key_reg;
    logic [IW-1:0]           rcnt_reg;
    logic [IW-1:0]           rank_mem [MAX_VERTICES];
    logic [IW-1:0]           slot_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] radj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_reg, acc_reg;
    logic [IW-1:0]           ri_reg;

    // search state
    logic [MAX_VERTICES-1:0] visited_reg, onstk_reg;
    logic [IW-1:0]           cnt_reg;
    logic [CW-1:0]           csp_reg, depth_reg, ncomp_reg;
    logic [IW-1:0]           callv_mem  [MAX_VERTICES];
    logic [CW-1:0]           callk_mem  [MAX_VERTICES];
    logic [IW-1:0]           vnum_mem   [MAX_VERTICES];
    logic [IW-1:0]           low_mem    [MAX_VERTICES];
    logic [IW-1:0]           cstk_mem   [MAX_VERTICES];
    logic [IW-1:0]           compof_mem [MAX_VERTICES];
    logic [CW-1:0]           csize_mem  [MAX_VERTICES];
    logic [IW-1:0]           x_reg, v_reg, lowv_reg;
    logic [CW-1:0]           size_reg;

    // ordering and emission
    logic [IW-1:0]           best_reg;
    logic [CW-1:0]           best_size_reg, seen_reg, crank_reg;
    logic [MAX_VERTICES-1:0] done_reg;
    logic [COUNT_W-1:0]      count_reg;

    // output register
    logic                  out_valid_reg;
    logic [COMP_NUM_W-1:0] out_comp_reg;
    logic [LETTER_W-1:0]   out_letter_reg;
    logic [SIZE_W-1:0]     out_size_reg;
    logic                  out_last_comp_reg, out_last_run_reg, out_empty_reg, out_ovf_reg;

    // combinational reads
    logic [CW-1:0]           depth_m1, csp_m1;
    logic [IW-1:0]           tidx, top_v, w, vnum_addr, vnum_rd, low_rd, cstk_rd;
    logic [CW-1:0]           top_k;
    logic [MAX_VERTICES:0]   low_mask;
    logic [MAX_VERTICES-1:0] rest;
    logic [LETTER_W-1:0]     find_key, letter_rd;
    logic [IW-1:0]           letter_addr, slot_rd, rank_addr, rank_rd, compof_rd;
    logic [CW-1:0]           csize_rd;
    logic [7:0]              total;
    logic                    full;

    assign i_idx    = i_reg[IW-1:0];
    assign j_idx    = j_reg[IW-1:0];
    assign depth_m1 = depth_reg - CW'(1);
    assign csp_m1   = csp_reg - CW'(1);
    assign tidx     = depth_m1[IW-1:0];
    assign top_v    = callv_mem[tidx];
    assign top_k    = callk_mem[tidx];
    assign low_mask = {(MAX_VERTICES + 1){1'b1}} << top_k;
    assign rest     = radj_mem[top_v] & low_mask[MAX_VERTICES-1:0];

    // lowest neighbor at or above the resume index
    always_comb begin
        w = '0;
        for (int b = MAX_VERTICES - 1; b >= 0; b--) begin
            if (rest[b]) begin
                w = IW'(b);
            end
        end
    end

    assign vnum_addr   = (|rest) ? w : top_v;
    assign vnum_rd     = vnum_mem[vnum_addr];
    assign low_rd      = low_mem[top_v];
    assign cstk_rd     = cstk_mem[csp_m1[IW-1:0]];
    assign find_key    = cmd.find_b ? second_reg : first_reg;
    assign slot_rd     = slot_mem[j_idx];
    assign letter_addr = cmd.rk_load ? i_idx : (cmd.emit_out ? slot_rd : j_idx);
    assign letter_rd   = letter_mem[letter_addr];
    assign rank_addr   = cmd.rm_load ? i_idx : j_idx;
    assign rank_rd     = rank_mem[rank_addr];
    assign compof_rd   = compof_mem[j_idx];
    assign csize_rd    = csize_mem[i_idx];
    assign full        = (vcount_reg == CW'(MAX_VERTICES));
    assign total       = (8'(vcount_reg) < 8'(RESULT_LIMIT)) ? 8'(vcount_reg) : 8'(RESULT_LIMIT);

    always_comb begin
        stat.n_zero     = (vcount_reg == '0);
        stat.j_end      = (j_reg == vcount_reg);
        stat.i_end      = (i_reg == vcount_reg);
        stat.find_hit   = (letter_rd == find_key);
        stat.root_seen  = visited_reg[i_idx];
        stat.rest_any   = |rest;
        stat.w_new      = !visited_reg[w];
        stat.is_root    = (low_rd == vnum_rd);
        stat.pop_last   = (cstk_rd == v_reg) || (csp_reg == CW'(1));
        stat.depth_zero = (depth_reg == '0);
        stat.sel_end    = (i_reg == ncomp_reg);
        stat.best_none  = (best_size_reg == '0);
        stat.r_match    = (compof_rd == best_reg);
        stat.out_free   = !out_valid_reg || out_ready;
        stat.run_last   = ((8'(count_reg) + 8'd1) == total);
    end

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg    <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < MAX_VERTICES; r++) begin
                adj_reg[r] <= '0;
            end
        end else begin
            if (cmd.clear) begin
                vcount_reg <= '0;
                ovf_reg    <= 1'b0;
                for (int r = 0; r < MAX_VERTICES; r++) begin
                    adj_reg[r] <= '0;
                end
            end
            if (cmd.find_miss) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    vcount_reg <= vcount_reg + CW'(1);
                end
            end
            if (cmd.edge_set && edge_reg && a_ok_reg && b_ok_reg) begin
                adj_reg[a_idx_reg][b_idx_reg] <= 1'b1;
            end
            if (cmd.out_empty || cmd.emit_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, scratch and stores
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            first_reg  <= in_first;
            second_reg <= in_second;
            edge_reg   <= in_edge;
            j_reg      <= '0;
        end
        if (cmd.find_step) begin
            j_reg <= j_reg + CW'(1);
        end
        if (cmd.find_hit) begin
            j_reg <= '0;
            if (cmd.find_b) begin
                b_idx_reg <= j_idx;
                b_ok_reg  <= 1'b1;
            end else begin
                a_idx_reg <= j_idx;
                a_ok_reg  <= 1'b1;
            end
        end
        if (cmd.find_miss) begin
            j_reg <= '0;
            if (!full) begin
                letter_mem[vcount_reg[IW-1:0]] <= find_key;
            end
            if (cmd.find_b) begin
                b_idx_reg <= vcount_reg[IW-1:0];
                b_ok_reg  <= !full;
            end else begin
                a_idx_reg <= vcount_reg[IW-1:0];
                a_ok_reg  <= !full;
            end
        end

        if (cmd.ana_start || cmd.i_clear) begin
            i_reg <= '0;
        end
        if (cmd.rk_load) begin
            key_reg  <= letter_rd;
            rcnt_reg <= '0;
            j_reg    <= '0;
        end
        if (cmd.rk_scan) begin
            if (letter_rd < key_reg) begin
                rcnt_reg <= rcnt_reg + IW'(1);
            end
            j_reg <= j_reg + CW'(1);
        end
        if (cmd.rk_store) begin
            rank_mem[i_idx]    <= rcnt_reg;
            slot_mem[rcnt_reg] <= i_idx;
            i_reg              <= i_reg + CW'(1);
        end
        if (cmd.rm_load) begin
            row_reg <= adj_reg[i_idx];
            ri_reg  <= rank_rd;
            acc_reg <= '0;
            j_reg   <= '0;
        end
        if (cmd.rm_scan) begin
            if (row_reg[j_idx]) begin
                acc_reg[rank_rd] <= 1'b1;
            end
            j_reg <= j_reg + CW'(1);
        end
        if (cmd.rm_store) begin
            radj_mem[ri_reg] <= acc_reg;
            i_reg            <= i_reg + CW'(1);
        end

        if (cmd.t_init) begin
            i_reg       <= '0;
            visited_reg <= '0;
            onstk_reg   <= '0;
            cnt_reg     <= '0;
            csp_reg     <= '0;
            depth_reg   <= '0;
            ncomp_reg   <= '0;
            crank_reg   <= '0;
            count_reg   <= '0;
            done_reg    <= '0;
        end
        if (cmd.root_skip) begin
            i_reg <= i_reg + CW'(1);
        end
        if (cmd.root_pick) begin
            x_reg <= i_idx;
        end
        if (cmd.visit) begin
            vnum_mem[x_reg]                <= cnt_reg;
            low_mem[x_reg]                 <= cnt_reg;
            cnt_reg                        <= cnt_reg + IW'(1);
            visited_reg[x_reg]             <= 1'b1;
            onstk_reg[x_reg]               <= 1'b1;
            cstk_mem[csp_reg[IW-1:0]]      <= x_reg;
            csp_reg                        <= csp_reg + CW'(1);
            callv_mem[depth_reg[IW-1:0]]   <= x_reg;
            callk_mem[depth_reg[IW-1:0]]   <= '0;
            depth_reg                      <= depth_reg + CW'(1);
        end
        if (cmd.step_adv) begin
            callk_mem[tidx] <= CW'(w) + CW'(1);
            if (!visited_reg[w]) begin
                x_reg <= w;
            end else if (onstk_reg[w] && (vnum_rd < low_rd)) begin
                low_mem[top_v] <= vnum_rd;
            end
        end
        if (cmd.step_done) begin
            depth_reg <= depth_m1;
            v_reg     <= top_v;
            lowv_reg  <= low_rd;
            size_reg  <= '0;
        end
        if (cmd.pop) begin
            csp_reg              <= csp_m1;
            onstk_reg[cstk_rd]   <= 1'b0;
            compof_mem[cstk_rd]  <= ncomp_reg[IW-1:0];
            size_reg             <= size_reg + CW'(1);
            if (stat.pop_last) begin
                csize_mem[ncomp_reg[IW-1:0]] <= size_reg + CW'(1);
                ncomp_reg                    <= ncomp_reg + CW'(1);
            end
        end
        // pull the parent's low link down to the child's
        if (cmd.ret_upd) begin
            if (lowv_reg < low_rd) begin
                low_mem[top_v] <= lowv_reg;
            end
        end

        if (cmd.sel_start || cmd.emit_next) begin
            i_reg         <= '0;
            best_size_reg <= '0;
        end
        // strict compare keeps the earliest finished component on a tie
        if (cmd.sel_scan) begin
            if (!done_reg[i_idx] && (csize_rd > best_size_reg)) begin
                best_reg      <= i_idx;
                best_size_reg <= csize_rd;
            end
            i_reg <= i_reg + CW'(1);
        end
        if (cmd.emit_start) begin
            j_reg    <= '0;
            seen_reg <= '0;
        end
        if (cmd.emit_skip) begin
            j_reg <= j_reg + CW'(1);
        end
        if (cmd.emit_out) begin
            j_reg             <= j_reg + CW'(1);
            seen_reg          <= seen_reg + CW'(1);
            count_reg         <= count_reg + COUNT_W'(1);
            out_comp_reg      <= COMP_NUM_W'(crank_reg);
            out_letter_reg    <= letter_rd;
            out_size_reg      <= SIZE_W'(best_size_reg);
            out_last_comp_reg <= ((seen_reg + CW'(1)) == best_size_reg);
            out_last_run_reg  <= stat.run_last;
            out_empty_reg     <= 1'b0;
            out_ovf_reg       <= ovf_reg;
        end
        if (cmd.emit_next) begin
            done_reg[best_reg] <= 1'b1;
            crank_reg          <= crank_reg + CW'(1);
        end
        if (cmd.out_empty) begin
            out_comp_reg      <= '0;
            out_letter_reg    <= '0;
            out_size_reg      <= '0;
            out_last_comp_reg <= 1'b0;
            out_last_run_reg  <= 1'b1;
            out_empty_reg     <= 1'b1;
            out_ovf_reg       <= ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_comp      = out_comp_reg;
    assign out_letter    = out_letter_reg;
    assign out_size      = out_size_reg;
    assign out_last_comp = out_last_comp_reg;
    assign out_last_run  = out_last_run_reg;
    assign out_empty     = out_empty_reg;
    assign out_ovf       = out_ovf_reg;

endmodule

@@ rtl/core/strongly_connected_components.sv @@
// Top level: strongly connected components of a directed letter graph.
//
//  Channel  Direction  Moves
//  s_       in         one request: clear, add bigram, or analyse
//  m_       out        one vertex result per request item, components largest first
//
// One request at a time. Add bigram runs a sequential letter search over the N stored
// letters. Analyse works through the single-port letter, rank and component stores.
// Reset is synchronous, active low, and empties the graph. A stalled result holds
// in the output register; emission waits for it to be taken.
`timescale 1ns / 1ps

module strongly_connected_components import scc_pkg::*; #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // first_letter, second_letter, edge_present
    input  logic [OP_W-1:0]      s_tuser,  // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // component_number, letter, component_size, last_of_component, overflow
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,  // last_of_run
    output logic [0:0]           m_tuser   // graph_empty
);

    scc_cmd_t              cmd;
    scc_stat_t             stat;
    logic [COMP_NUM_W-1:0] out_comp;
    logic [LETTER_W-1:0]   out_letter;
    logic [SIZE_W-1:0]     out_size;
    logic                  out_last_comp, out_last_run, out_empty, out_ovf;

    scc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_op    (s_tuser),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    scc_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_first      (s_tdata[LETTER_W-1:0]),
        .in_second     (s_tdata[2*LETTER_W-1:LETTER_W]),
        .in_edge       (s_tdata[2*LETTER_W]),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_comp      (out_comp),
        .out_letter    (out_letter),
        .out_size      (out_size),
        .out_last_comp (out_last_comp),
        .out_last_run  (out_last_run),
        .out_empty     (out_empty),
        .out_ovf       (out_ovf)
    );

    assign m_tdata = {6'b0, out_ovf, out_last_comp, out_size, out_letter, out_comp};
    assign m_tlast = out_last_run;
    assign m_tuser = out_empty;

endmodule

@@ sim/scc_checker.sv @@
// Checker: predicts the component stream of each analyse request and compares results.
`timescale 1ns / 1ps

module scc_checker import scc_pkg::*; #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic [0:0]           m_tuser,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [COMP_NUM_W-1:0] comp;
        logic [LETTER_W-1:0]   letter;
        logic [SIZE_W-1:0]     size;
        logic                  last_comp;
        logic                  last_run;
        logic                  empty;
        logic                  ovf;
    } vertex_result_t;

    vertex_result_t      comp_q[$];
    logic [LETTER_W-1:0] letters[MAX_VERTICES];
    logic [63:0]         adj[MAX_VERTICES];
    int                  nvert;
    logic                ovf_flag;

    assign pending = comp_q.size();

    function automatic int insert_letter(logic [LETTER_W-1:0] code);
        for (int i = 0; i < nvert; i++)
            if (letters[i] == code) return i;
        if (nvert >= MAX_VERTICES) begin
            ovf_flag = 1'b1;
            return -1;
        end
        letters[nvert] = code;
        nvert++;
        return nvert - 1;
    endfunction

    // Tarjan over letter-ranked vertices, then queue one result per vertex (one empty result if none).
    function automatic void predict_components();
        int rank_of[MAX_VERTICES], slot_of[MAX_VERTICES];
        logic [63:0] radj[MAX_VERTICES];
        int num[MAX_VERTICES], low[MAX_VERTICES], cs[MAX_VERTICES];
        int call_v[MAX_VERTICES], call_k[MAX_VERTICES];
        int comp_of[MAX_VERTICES], csize[MAX_VERTICES], order[MAX_VERTICES];
        logic [63:0] seen_v, on_stk, rest;
        int counter, csp, depth, ncomp, r, v, k, w, p, sz, j, c, total, count, got;
        vertex_result_t res;
        if (nvert == 0) begin
            res = '0;
            res.last_run = 1'b1;
            res.empty = 1'b1;
            res.ovf = ovf_flag;
            comp_q.insert(comp_q.size(), res);
            return;
        end
        for (int i = 0; i < nvert; i++) begin
            r = 0;
            for (int q = 0; q < nvert; q++) if (letters[q] < letters[i]) r++;
            rank_of[i] = r;
            slot_of[r] = i;
        end
        for (int i = 0; i < nvert; i++) begin
            radj[rank_of[i]] = '0;
            for (int q = 0; q < nvert; q++)
                if (adj[i][q]) radj[rank_of[i]][rank_of[q]] = 1'b1;
        end
        seen_v = '0; on_stk = '0;
        counter = 0; csp = 0; depth = 0; ncomp = 0;
        for (int root = 0; root < nvert; root++) begin
            if (seen_v[root]) continue;
            w = root;
            num[w] = counter; low[w] = counter; counter++;
            seen_v[w] = 1'b1; on_stk[w] = 1'b1;
            cs[csp] = w; csp++;
            call_v[depth] = w; call_k[depth] = 0; depth++;
            while (depth > 0) begin
                v = call_v[depth-1];
                k = call_k[depth-1];
                rest = (k < nvert) ? (radj[v] & ({64{1'b1}} << k)) : '0;
                if (rest != 0) begin
                    w = 0;
                    while (!rest[w]) w++;
                    call_k[depth-1] = w + 1;
                    if (!seen_v[w]) begin
                        num[w] = counter; low[w] = counter; counter++;
                        seen_v[w] = 1'b1; on_stk[w] = 1'b1;
                        cs[csp] = w; csp++;
                        call_v[depth] = w; call_k[depth] = 0; depth++;
                    end else if (on_stk[w] && num[w] < low[v]) begin
                        low[v] = num[w];
                    end
                end else begin
                    depth--;
                    if (low[v] == num[v]) begin
                        sz = 0;
                        do begin
                            csp--;
                            w = cs[csp];
                            on_stk[w] = 1'b0;
                            comp_of[w] = ncomp;
                            sz++;
                        end while (w != v && csp > 0);
                        csize[ncomp] = sz;
                        ncomp++;
                    end
                    if (depth > 0) begin
                        p = call_v[depth-1];
                        if (low[v] < low[p]) low[p] = low[v];
                    end
                end
            end
        end
        // larger first, ties keep completion order
        for (int i = 0; i < ncomp; i++) begin
            j = i;
            while (j > 0 && csize[order[j-1]] < csize[i]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        total = nvert < RESULT_LIMIT ? nvert : RESULT_LIMIT;
        count = 0;
        for (int i = 0; i < ncomp && count < total; i++) begin
            c = order[i];
            got = 0;
            for (int q = 0; q < nvert && count < total; q++) begin
                if (comp_of[q] != c) continue;
                got++;
                res.comp = COMP_NUM_W'(i);
                res.letter = letters[slot_of[q]];
                res.size = SIZE_W'(csize[c]);
                res.last_comp = (got == csize[c]);
                res.last_run = (count + 1 == total);
                res.empty = 1'b0;
                res.ovf = ovf_flag;
                comp_q.insert(comp_q.size(), res);
                count++;
            end
        end
    endfunction

    function automatic void clear_graph();
        nvert = 0;
        ovf_flag = 1'b0;
        for (int i = 0; i < MAX_VERTICES; i++) adj[i] = '0;
    endfunction

    initial begin
        fail_count = 0;
        clear_graph();
    end

    always @(posedge aclk) begin
        int a, b;
        vertex_result_t want, seen;
        if (!aresetn) begin
            clear_graph();
            comp_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    OP_CLEAR: clear_graph();
                    OP_ADD: begin
                        a = insert_letter(s_tdata[20:0]);
                        b = insert_letter(s_tdata[41:21]);
                        if (s_tdata[42] && a >= 0 && b >= 0) adj[a][b] = 1'b1;
                    end
                    OP_ANALYSE: predict_components();
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                seen.comp = m_tdata[4:0];
                seen.letter = m_tdata[25:5];
                seen.size = m_tdata[31:26];
                seen.last_comp = m_tdata[32];
                seen.ovf = m_tdata[33];
                seen.last_run = m_tlast;
                seen.empty = m_tuser[0];
                if (comp_q.size() == 0) begin
                    $error("unexpected result %h", seen);
                    fail_count++;
                end else begin
                    want = comp_q.pop_front();
                    if (seen.comp != want.comp) begin
                        $error("component_number exp %0d got %0d", want.comp, seen.comp);
                        fail_count++;
                    end
                    if (seen.letter != want.letter) begin
                        $error("letter exp %h got %h", want.letter, seen.letter);
                        fail_count++;
                    end
                    if (seen.size != want.size) begin
                        $error("component_size exp %0d got %0d", want.size, seen.size);
                        fail_count++;
                    end
                    if (seen.last_comp != want.last_comp) begin
                        $error("last_of_component exp %0d got %0d",
                               want.last_comp, seen.last_comp);
                        fail_count++;
                    end
                    if (seen.last_run != want.last_run) begin
                        $error("last_of_run exp %0d got %0d", want.last_run, seen.last_run);
                        fail_count++;
                    end
                    if (seen.empty != want.empty) begin
                        $error("graph_empty exp %0d got %0d", want.empty, seen.empty);
                        fail_count++;
                    end
                    if (seen.ovf != want.ovf) begin
                        $error("overflow exp %0d got %0d", want.ovf, seen.ovf);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench top: drives graph requests and result back-pressure, gives the verdict.
`timescale 1ns / 1ps

module tb_top;
    import scc_pkg::*;

    localparam int IDLE_LIMIT = 40000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [0:0]           m_tuser;
    int                   fail_count, pending, sent, idle_cycles;
    logic                 quiet = 1'b0;
    logic                 held_off = 1'b0;
    logic [LETTER_W-1:0]  pool[40];

    always #6 aclk = ~aclk;

    strongly_connected_components u_dut (.*);

    scc_checker u_chk (.*);

    task automatic send_request(logic [OP_W-1:0] op, logic [LETTER_W-1:0] a,
                                logic [LETTER_W-1:0] b, logic e);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'd0, e, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    // receiver: random stall bursts, one long hold-off to back up the block
    initial begin
        int len;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held_off && sent > 120) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (500) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                len = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (len - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[strongly_connected_components] ERROR");
            $finish;
        end
    end

    initial begin
        int nadd, psize;
        logic [LETTER_W-1:0] a, b;
        sent = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty graph, unused code, extremes, self loop, repeated and absent edges
        send_request(OP_ANALYSE, '0, '0, 1'b0);
        send_request(OP_UNUSED, 21'h1FFFFF, 21'h1FFFFF, 1'b1);
        send_request(OP_ADD, 21'd0, 21'h10FFFF, 1'b1);
        send_request(OP_ADD, 21'h10FFFF, 21'd0, 1'b1);
        send_request(OP_ADD, 21'h0F0000, 21'h0F0000, 1'b1);
        send_request(OP_ADD, 21'd0, 21'h10FFFF, 1'b1);
        send_request(OP_ADD, 21'h0AAAAA, 21'h055555, 1'b0);
        send_request(OP_ANALYSE, '0, '0, 1'b0);
        // fill past capacity: pairs of distinct letters, edges to dropped ones vanish
        for (int i = 0; i < 15; i++)
            send_request(OP_ADD, 21'(1000 + 2 * i), 21'(1001 + 2 * i), 1'b1);
        send_request(OP_ANALYSE, '0, '0, 1'b0);
        send_request(OP_CLEAR, '0, '0, 1'b0);
        send_request(OP_ANALYSE, '0, '0, 1'b0);

        while (sent < 310) begin
            if (sent > 270) quiet = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                // noise
                send_request(OP_W'($urandom_range(0, 3)),
                             LETTER_W'($urandom_range(0, 1114111)),
                             LETTER_W'($urandom_range(0, 1114111)), 1'($urandom));
            end else begin
                if ($urandom_range(0, 2) != 0) send_request(OP_CLEAR, '0, '0, 1'b0);
                psize = $urandom_range(0, 5) == 0 ? 40 : $urandom_range(2, 12);
                for (int i = 0; i < psize; i++)
                    pool[i] = LETTER_W'($urandom_range(0, 1114111));
                nadd = $urandom_range(0, 5) == 0 ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 10);
                for (int i = 0; i < nadd; i++) begin
                    a = pool[$urandom_range(0, psize - 1)];
                    b = pool[$urandom_range(0, psize - 1)];
                    send_request(OP_ADD, a, b, $urandom_range(0, 4) != 0);
                end
                send_request(OP_ANALYSE, '0, '0, 1'b0);
            end
        end
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (3200) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("[strongly_connected_components] OK");
        else
            $display("[strongly_connected_components] ERROR");
        $finish;
    end

endmodule
